@@ rtl/pcx_pkg.sv @@
package pcx_pkg;

    // Field widths and fixed codes of the PCX run-length format
    localparam int PIXEL_W = 8;
    localparam int RUN_W   = 6;

    localparam logic [RUN_W-1:0]   RUN_LIMIT  = 6'd63;
    localparam logic [PIXEL_W-1:0] COUNT_BASE = 8'd192;

    // Default depth of the run command queue
    localparam int QUEUE_DEPTH_DEF = 4;

    // One input item
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               final_pixel;
    } pix_item_t;

    // One result item
    typedef struct packed {
        logic [PIXEL_W-1:0] code_byte;
        logic               group_end;
        logic               image_end;
    } code_item_t;

    // One finished run, as handed from the run tracker to the byte packer
    typedef struct packed {
        logic [PIXEL_W-1:0] value;
        logic [RUN_W-1:0]   length;
        logic               group_end;
        logic               image_end;
    } run_cmd_t;

    // Up to two runs pushed in one cycle; cmd_a is always used first
    typedef struct packed {
        logic     first;
        logic     second;
        run_cmd_t cmd_a;
        run_cmd_t cmd_b;
    } q_push_t;

    // Head of the queue as seen by the byte packer
    typedef struct packed {
        logic     valid;
        run_cmd_t cmd;
    } q_head_t;

endpackage

@@ rtl/pcx_front.sv @@
module pcx_front
    import pcx_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_valid,
    output logic                pix_stall,
    input  pix_item_t           pix_data,
    input  logic                cfg_write,
    input  logic [RUN_W-1:0]    cfg_data,
    input  logic                q_room2,
    output q_push_t             push
);

    logic [PIXEL_W-1:0] run_val_reg;
    logic [PIXEL_W-1:0] run_val_next;
    logic [RUN_W-1:0]   run_len_reg;
    logic [RUN_W-1:0]   run_len_next;
    logic [RUN_W-1:0]   max_run_reg;
    logic [RUN_W-1:0]   limit;
    logic [RUN_W-1:0]   new_len;
    logic               accept;
    logic               brk;
    logic               ext;
    run_cmd_t           cmd_brk;
    run_cmd_t           cmd_flush;

    // Hold off new pixels unless the queue can take a break and a flush
    assign pix_stall = !q_room2;
    assign accept    = pix_valid && !pix_stall;

    // Classify the pixel against the pending run
    always_comb
    begin
        limit   = (max_run_reg == '0) ? RUN_W'(1) : max_run_reg;
        brk     = (run_len_reg != '0) &&
                  !((pix_data.pixel == run_val_reg) && (run_len_reg < limit));
        ext     = (run_len_reg != '0) && !brk;
        new_len = ext ? (run_len_reg + RUN_W'(1)) : RUN_W'(1);

        cmd_brk.value       = run_val_reg;
        cmd_brk.length      = run_len_reg;
        cmd_brk.group_end   = !pix_data.final_pixel;
        cmd_brk.image_end   = 1'b0;

        cmd_flush.value     = pix_data.pixel;
        cmd_flush.length    = new_len;
        cmd_flush.group_end = 1'b1;
        cmd_flush.image_end = 1'b1;

        push.first  = accept && (brk || pix_data.final_pixel);
        push.second = accept && brk && pix_data.final_pixel;
        push.cmd_a  = brk ? cmd_brk : cmd_flush;
        push.cmd_b  = cmd_flush;

        run_val_next = run_val_reg;
        run_len_next = run_len_reg;
        if (accept)
        begin
            if (pix_data.final_pixel)
            begin
                run_val_next = '0;
                run_len_next = '0;
            end
            else
            begin
                run_val_next = pix_data.pixel;
                run_len_next = new_len;
            end
        end
    end

    // Run state and the maximum run register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_val_reg <= '0;
            run_len_reg <= '0;
            max_run_reg <= RUN_LIMIT;
        end
        else
        begin
            run_val_reg <= run_val_next;
            run_len_reg <= run_len_next;
            if (cfg_write)
            begin
                max_run_reg <= cfg_data;
            end
        end
    end

endmodule

@@ rtl/pcx_queue.sv @@
module pcx_queue
    import pcx_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_push_t push,
    input  logic    pop,
    output q_head_t head,
    output logic    room2
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

    run_cmd_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  wr_ptr_b;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : (p + PTR_W'(1));
    endfunction

    assign do_pop     = pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = slot_reg[rd_ptr_reg];
    assign room2      = (count_reg <= ROOM_MAX);

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_b    = ptr_inc(wr_ptr_reg);
        wr_ptr_next = wr_ptr_reg;
        if (push.first && push.second)
        begin
            wr_ptr_next = ptr_inc(wr_ptr_b);
        end
        else if (push.first)
        begin
            wr_ptr_next = wr_ptr_b;
        end
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push.first) + CNT_W'(push.second)
                      - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed runs
    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            slot_reg[wr_ptr_reg] <= push.cmd_a;
        end
        if (push.first && push.second)
        begin
            slot_reg[wr_ptr_b] <= push.cmd_b;
        end
    end

endmodule

@@ rtl/pcx_back.sv @@
module pcx_back
    import pcx_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_head_t    head,
    output logic       pop,
    output logic       code_valid,
    input  logic       code_stall,
    output code_item_t code_data
);

    logic       out_valid_reg;
    logic       out_valid_next;
    code_item_t out_data_reg;
    code_item_t out_data_next;
    logic       phase_reg;
    logic       phase_next;
    logic       load;
    logic       literal;

    assign code_valid = out_valid_reg;
    assign code_data  = out_data_reg;

    // Refill the output register when empty or when its byte transfers
    assign load    = !out_valid_reg || !code_stall;
    assign literal = (head.cmd.length == RUN_W'(1)) && (head.cmd.value < COUNT_BASE);

    // Turn the head run into a literal, or a count byte then a value byte
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        phase_next     = phase_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = head.valid;
            if (head.valid)
            begin
                if (literal || phase_reg)
                begin
                    out_data_next.code_byte = head.cmd.value;
                    out_data_next.group_end = head.cmd.group_end;
                    out_data_next.image_end = head.cmd.image_end;
                    phase_next              = 1'b0;
                    pop                     = 1'b1;
                end
                else
                begin
                    out_data_next.code_byte = COUNT_BASE + {2'b00, head.cmd.length};
                    out_data_next.group_end = 1'b0;
                    out_data_next.image_end = 1'b0;
                    phase_next              = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

@@ rtl/pcx_rle_encoder_top.sv @@
// Channel   Handshake          Payload           Transfer when
// pix       pix_valid/stall    pix_item_t        pix_valid && !pix_stall
// code      code_valid/stall   code_item_t       code_valid && !code_stall
// cfg       cfg_valid/ready    max_run, 6 bits   cfg_valid && cfg_ready
//
// A pixel is taken every cycle while the run queue has room for two runs.
// Output is one byte per cycle while code_stall is low: a literal is one byte, any other
// run two (count byte, then value byte), so the byte packer sets the sustained rate.
// The pixel transfer closing a run queues it; the output register loads it from the head.
// Reset clears the run state, the queue and the output valid flag; max_run = 63.
// An output stall holds the byte; the queue then fills and stalls pixel input.
module pcx_rle_encoder_top
    import pcx_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pix_valid,
    output logic             pix_stall,
    input  pix_item_t        pix_data,
    output logic             code_valid,
    input  logic             code_stall,
    output code_item_t       code_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [RUN_W-1:0] cfg_data
);

    q_push_t push;
    q_head_t head;
    logic    room2;
    logic    pop;

    assign cfg_ready = 1'b1;

    pcx_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .q_room2   (room2),
        .push      (push)
    );

    pcx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .room2 (room2)
    );

    pcx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_data  (code_data)
    );

endmodule

@@ rtl/pcx_checker.sv @@
module pcx_checker
    import pcx_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             pix_valid,
    input logic             pix_stall,
    input pix_item_t        pix_data,
    input logic             code_valid,
    input logic             code_stall,
    input code_item_t       code_data,
    input logic             cfg_valid,
    input logic             cfg_ready,
    input logic [RUN_W-1:0] cfg_data
);

    // Hold a stalled output byte
    a_code_hold: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_stall |=> code_valid && $stable(code_data))
        else $error("stalled output byte changed");

    // Close the group on the last byte of an image
    a_image_group: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && code_data.image_end |-> code_data.group_end)
        else $error("image end without group end");

    // Show no output right after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !code_valid)
        else $error("output valid right after reset");

    // Never refuse a configuration write
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind pcx_rle_encoder_top pcx_checker u_pcx_checker (.*);

@@ tb/pcx_rle_encoder_top_tb.sv @@
`timescale 1ns / 1ps

import pcx_pkg::*;

// Tracks the run state of the encoder and holds the code bytes it must emit
class pcx_code_scoreboard;
    code_item_t          expected_codes[$];
    logic [RUN_W-1:0]    max_run_reg;
    logic [PIXEL_W-1:0]  run_val;
    logic [RUN_W-1:0]    run_len;
    int                  mismatches;

    function new();
        max_run_reg = RUN_LIMIT;
        run_val     = '0;
        run_len     = '0;
        mismatches  = 0;
    endfunction

    function void set_max_run(logic [RUN_W-1:0] value);
        max_run_reg = value;
    endfunction

    function void push_byte(logic [PIXEL_W-1:0] value);
        code_item_t c;
        c           = '0;
        c.code_byte = value;
        expected_codes.push_back(c);
    endfunction

    // Emit the pending run: a lone low byte as itself, anything else as count + value
    function void push_run();
        if (run_len == RUN_W'(1) && run_val < COUNT_BASE)
        begin
            push_byte(run_val);
        end
        else
        begin
            push_byte(COUNT_BASE + PIXEL_W'(run_len));
            push_byte(run_val);
        end
    endfunction

    // Advance the run state by one accepted pixel transfer
    function void note_pixel(pix_item_t item);
        logic [RUN_W-1:0] lim;
        int               n_before;
        int               last_idx;
        lim      = (max_run_reg == '0) ? RUN_W'(1) : max_run_reg;
        n_before = expected_codes.size();
        if (run_len == '0)
        begin
            run_val = item.pixel;
            run_len = RUN_W'(1);
        end
        else if (item.pixel == run_val && run_len < lim)
        begin
            run_len = run_len + RUN_W'(1);
        end
        else
        begin
            push_run();
            run_val = item.pixel;
            run_len = RUN_W'(1);
        end
        // Flush on the last pixel of the image and start over
        if (item.final_pixel)
        begin
            push_run();
            last_idx = expected_codes.size() - 1;
            expected_codes[last_idx].image_end = 1'b1;
            run_val = '0;
            run_len = '0;
        end
        if (expected_codes.size() > n_before)
        begin
            last_idx = expected_codes.size() - 1;
            expected_codes[last_idx].group_end = 1'b1;
        end
    endfunction

    // Compare one accepted code transfer with the oldest expectation
    function void check_code(code_item_t got);
        code_item_t want;
        if (expected_codes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected code byte=%h group_end=%b image_end=%b",
                         got.code_byte, got.group_end, got.image_end);
        end
        else
        begin
            want = expected_codes.pop_front();
            if (got.code_byte !== want.code_byte || got.group_end !== want.group_end ||
                got.image_end !== want.image_end)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: code mismatch exp byte=%h ge=%b ie=%b got byte=%h ge=%b ie=%b",
                             want.code_byte, want.group_end, want.image_end,
                             got.code_byte, got.group_end, got.image_end);
            end
        end
    endfunction
endclass

module pcx_rle_encoder_top_tb;
    import pcx_pkg::*;

    logic             clk;
    logic             rst_n;
    logic             pix_valid;
    logic             pix_stall;
    pix_item_t        pix_data;
    logic             code_valid;
    logic             code_stall;
    code_item_t       code_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [RUN_W-1:0] cfg_data;

    pcx_code_scoreboard sb;

    int cur_max_run;
    int burst_left;
    int phase_sent;
    int hold_req;

    pcx_rle_encoder_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix_data   (pix_data),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_data  (code_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit on the run
    initial
    begin
        #3ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Observe every transfer on the three channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_max_run(cfg_data);
            if (pix_valid && !pix_stall)
                sb.note_pixel(pix_data);
            if (code_valid && !code_stall)
                sb.check_code(code_data);
        end
    end

    // Receiver stall pattern, with a long hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        int seg_left;
        int mode;
        hold_seen  = 0;
        hold_left  = 0;
        seg_left   = 0;
        mode       = 0;
        code_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                code_stall <= 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(5, 40);
                end
                seg_left--;
                case (mode)
                    0: code_stall <= 1'b0;
                    1: code_stall <= ($urandom_range(0, 1) == 1);
                    2: code_stall <= ~code_stall;
                    default: code_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Offer one pixel in bursts with random gaps; return after its transfer
    task automatic send_pixel(logic [PIXEL_W-1:0] value, logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                pix_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        pix_valid            <= 1'b1;
        pix_data.pixel       <= value;
        pix_data.final_pixel <= last;
        phase_sent++;
        do
            @(posedge clk);
        while (pix_stall);
    endtask

    // Stop offering and hold until every expected byte has come out
    task automatic wait_drained();
        pix_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.expected_codes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_max_run(logic [RUN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        cur_max_run = int'(value);
    endtask

    // One image: a few runs from a small palette, some noise, last pixel flagged
    task automatic send_image();
        logic [PIXEL_W-1:0] palette[4];
        logic [PIXEL_W-1:0] value;
        int                 n_runs;
        int                 lim;
        int                 len;
        int                 kind;
        lim = (cur_max_run == 0) ? 1 : cur_max_run;
        for (int i = 0; i < 4; i++)
            palette[i] = PIXEL_W'($urandom_range(0, 255));
        palette[3] = PIXEL_W'($urandom_range(COUNT_BASE, 255));
        n_runs     = $urandom_range(1, 6);
        for (int r = 0; r < n_runs; r++)
        begin
            kind  = $urandom_range(0, 9);
            value = palette[$urandom_range(0, 3)];
            if (kind <= 5)
                len = $urandom_range(1, 3);
            else if (kind <= 7)
                len = $urandom_range(4, 10);
            else if (kind == 8)
                len = $urandom_range((lim > 1) ? lim - 1 : 1, lim + 2);
            else
            begin
                len   = 1;
                value = PIXEL_W'($urandom_range(0, 255));
            end
            for (int k = 0; k < len; k++)
                send_pixel(value, (r == n_runs - 1) && (k == len - 1));
        end
    endtask

    task automatic random_phase(logic [RUN_W-1:0] setting, int budget, bit with_hold);
        int images;
        write_max_run(setting);
        phase_sent = 0;
        images     = 0;
        while (phase_sent < budget)
        begin
            if (with_hold && images == 1)
                hold_req++;
            send_image();
            images++;
        end
        wait_drained();
    endtask

    initial
    begin
        sb          = new();
        cur_max_run = RUN_LIMIT;
        burst_left  = 0;
        phase_sent  = 0;
        hold_req    = 0;
        rst_n       <= 1'b0;
        pix_valid   <= 1'b0;
        pix_data    <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, literal boundary, run break plus flush, lone final pixel
        send_pixel(8'h00, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hBF, 1'b0);
        send_pixel(8'hC0, 1'b0);
        send_pixel(8'hC0, 1'b0);
        send_pixel(8'hC1, 1'b1);
        send_pixel(8'h55, 1'b1);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'hAA, 1'b1);
        send_pixel(8'h7F, 1'b0);
        send_pixel(8'h80, 1'b1);
        send_pixel(8'hBF, 1'b1);
        wait_drained();

        // Directed: run limit hit repeatedly
        write_max_run(6'd2);
        for (int i = 0; i < 5; i++)
            send_pixel(8'h33, i == 4);
        wait_drained();

        // Directed: zero limit, every pixel closes its own run
        write_max_run(6'd0);
        for (int i = 0; i < 3; i++)
            send_pixel(8'hE0, i == 2);
        wait_drained();

        // Random images across several limits
        random_phase(6'd1, 40, 1'b0);
        random_phase(RUN_LIMIT, 50, 1'b1);
        random_phase(RUN_W'($urandom_range(2, 8)), 40, 1'b0);
        random_phase(RUN_W'($urandom_range(9, 62)), 45, 1'b1);
        random_phase(6'd0, 35, 1'b0);
        random_phase(RUN_W'($urandom_range(1, 63)), 40, 1'b0);

        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_codes.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            if (sb.expected_codes.size() != 0)
                $display("ERROR: %0d expected code bytes never arrived",
                         sb.expected_codes.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
